// ----- design/jerm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jerm_pkg
// Shared types and constants for the joystick event to RC mapper.
// ----------------------------------------------------------------------------
package jerm_pkg;

	typedef enum logic [1:0] {
		FUNC_AXIS = 2'd0,
		FUNC_DOWN = 2'd1,
		FUNC_UP   = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		REG_AXIS_MAP   = 3'd0,
		REG_BUTTON_MAP = 3'd1,
		REG_GEAR_POS   = 3'd2,
		REG_RC_MIN     = 3'd3,
		REG_RC_MAX     = 3'd4,
		REG_RC_CENTRE  = 3'd5,
		REG_DEADZONE   = 3'd6,
		REG_DISCRETE   = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_NEUT = 2'd0,
		KIND_MIN  = 2'd1,
		KIND_MAX  = 2'd2,
		KIND_CONT = 2'd3
	} map_kind_t;

	typedef struct packed {
		logic        [17:0] axis_map;
		logic        [31:0] button_map;
		logic        [5:0]  gear_pos;
		logic signed [15:0] rc_min;
		logic signed [15:0] rc_max;
		logic signed [15:0] rc_centre;
		logic        [14:0] deadzone;
		logic               discrete;
	} cfg_t;

	typedef struct packed {
		logic       upd_thr;
		logic       upd_str;
		logic       gear_set;
		logic [7:0] gear_val;
		logic       gear_clr;
		logic       arm_set;
		logic       arm_clr;
		logic       dis_set;
		logic       dis_clr;
		logic       changed;
	} ev_ctrl_t;

	localparam logic        [17:0] AXIS_MAP_RST   = 18'd1;
	localparam logic        [31:0] BUTTON_MAP_RST = 32'h0302_0100;
	localparam logic        [5:0]  GEAR_POS_RST   = 6'd8;
	localparam logic signed [15:0] RC_MIN_RST     = 16'sd1000;
	localparam logic signed [15:0] RC_MAX_RST     = 16'sd2000;
	localparam logic signed [15:0] RC_CENTRE_RST  = 16'sd1500;
	localparam logic        [14:0] DEADZONE_RST   = 15'd3277;
	localparam logic signed [15:0] RC_STATE_RST   = 16'sd1500;

endpackage

// ----- design/jerm_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jerm_cfg_regs
// Configuration register file behind an APB-style port, one word per register.
// ----------------------------------------------------------------------------
module jerm_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output jerm_pkg::cfg_t      cfg
);
	import jerm_pkg::*;

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign wr_en = psel && penable && pwrite;
	assign idx   = reg_idx_t'(paddr[4:2]);
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.axis_map   <= AXIS_MAP_RST;
			cfg_q.button_map <= BUTTON_MAP_RST;
			cfg_q.gear_pos   <= GEAR_POS_RST;
			cfg_q.rc_min     <= RC_MIN_RST;
			cfg_q.rc_max     <= RC_MAX_RST;
			cfg_q.rc_centre  <= RC_CENTRE_RST;
			cfg_q.deadzone   <= DEADZONE_RST;
			cfg_q.discrete   <= 1'b0;
		end else if (wr_en) begin
			case (idx)
				REG_AXIS_MAP:   cfg_q.axis_map   <= pwdata[17:0];
				REG_BUTTON_MAP: cfg_q.button_map <= pwdata;
				REG_GEAR_POS:   cfg_q.gear_pos   <= pwdata[5:0];
				REG_RC_MIN:     cfg_q.rc_min     <= $signed(pwdata[15:0]);
				REG_RC_MAX:     cfg_q.rc_max     <= $signed(pwdata[15:0]);
				REG_RC_CENTRE:  cfg_q.rc_centre  <= $signed(pwdata[15:0]);
				REG_DEADZONE:   cfg_q.deadzone   <= pwdata[14:0];
				REG_DISCRETE:   cfg_q.discrete   <= pwdata[0];
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_AXIS_MAP:   prdata = {14'd0, cfg_q.axis_map};
			REG_BUTTON_MAP: prdata = cfg_q.button_map;
			REG_GEAR_POS:   prdata = {26'd0, cfg_q.gear_pos};
			REG_RC_MIN:     prdata = 32'(cfg_q.rc_min);
			REG_RC_MAX:     prdata = 32'(cfg_q.rc_max);
			REG_RC_CENTRE:  prdata = 32'(cfg_q.rc_centre);
			REG_DEADZONE:   prdata = {17'd0, cfg_q.deadzone};
			REG_DISCRETE:   prdata = {31'd0, cfg_q.discrete};
			default:        prdata = 32'd0;
		endcase
	end

endmodule

// ----- design/jerm_axis_map.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jerm_axis_map
// Axis to RC value mapping in one combinational pass: deadzone, inversion,
// scaling with rounding toward zero, offset from centre and clamp.
// ----------------------------------------------------------------------------
module jerm_axis_map #(
	parameter int AXIS_BITS = 16
) (
	input  logic signed [15:0]  axis_value,
	input  logic                invert,
	input  jerm_pkg::cfg_t      cfg,
	output logic signed [15:0]  mapped
);
	import jerm_pkg::*;

	localparam int SHIFT = 16 - AXIS_BITS;
	localparam int NW    = 16 + SHIFT;
	localparam int PW    = NW + 17;
	localparam int VW    = PW - 14;

	logic signed [NW:0]   n;
	logic signed [NW:0]   m;
	logic signed [NW:0]   d;
	logic signed [NW:0]   neg_d;
	logic signed [16:0]   diff;
	logic signed [16:0]   diff_adj;
	logic signed [15:0]   half;
	logic                 in_dz;
	map_kind_t            kind;
	logic signed [PW-1:0] prod;

	logic signed [PW-1:0] biased;
	logic signed [VW-2:0] off;
	logic signed [VW-1:0] v;
	logic signed [VW-1:0] lo;
	logic signed [VW-1:0] hi;
	logic signed [VW-1:0] c1;
	logic signed [VW-1:0] c2;

	// q15 view of the axis, deadzone and inversion, then divide by 2^15
	// toward zero, offset from centre, clamp low then high
	always_comb begin
		n        = (NW+1)'(axis_value) <<< SHIFT;
		d        = $signed((NW+1)'(cfg.deadzone));
		neg_d    = -d;
		in_dz    = (n > neg_d) && (n < d);
		m        = invert ? -n : n;
		diff     = 17'(cfg.rc_max) - 17'(cfg.rc_min);
		diff_adj = diff + $signed({16'd0, diff[16]});
		half     = 16'(diff_adj >>> 1);
		prod     = m * half;
		if (in_dz) begin
			kind = KIND_NEUT;
		end else if (cfg.discrete) begin
			if (m > d) begin
				kind = KIND_MAX;
			end else if (m < neg_d) begin
				kind = KIND_MIN;
			end else begin
				kind = KIND_NEUT;
			end
		end else begin
			kind = KIND_CONT;
		end
		biased = prod + $signed(PW'(prod[PW-1] ? 15'h7fff : 15'h0000));
		off    = $signed(biased[PW-1:15]);
		v      = VW'(off) + VW'(cfg.rc_centre);
		lo     = VW'(cfg.rc_min);
		hi     = VW'(cfg.rc_max);
		c1     = (v < lo) ? lo : v;
		c2     = (c1 > hi) ? hi : c1;
		case (kind)
			KIND_NEUT: mapped = cfg.rc_centre;
			KIND_MIN:  mapped = cfg.rc_min;
			KIND_MAX:  mapped = cfg.rc_max;
			KIND_CONT: mapped = 16'(c2);
			default:   mapped = cfg.rc_centre;
		endcase
	end

endmodule

// ----- design/joystick_event_to_rc_mapper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_event_to_rc_mapper
// Maps joystick axis and button events onto RC throttle, steering, gear and
// arm state; every event returns one word with the whole state.
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// in        sink       in_valid / in_stall    func, control_id, axis_value
// out       source     out_valid / out_stall  throttle_out, steering_out,
//                                             gear_buttons, arm_request,
//                                             disarm_request, changed
// cfg       sink       apb psel / penable     paddr, pwdata, prdata
//
// one event per cycle sustained while out_stall stays low; a taken event passes
// through the input register and then the result register
// reset clears all valid flags and puts the control state at its reset value
// a stalled output holds its word; the input register moves on only when the
// result register is empty or emptying, so in_stall rises only when both are full
// ----------------------------------------------------------------------------
module joystick_event_to_rc_mapper #(
	parameter int AXIS_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic [7:0]         control_id,
	input  logic signed [15:0] axis_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] throttle_out,
	output logic signed [15:0] steering_out,
	output logic [7:0]         gear_buttons,
	output logic               arm_request,
	output logic               disarm_request,
	output logic               changed,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import jerm_pkg::*;

	cfg_t               cfg;

	logic               valid_s1;
	func_t              func_s1;
	logic [7:0]         id_s1;
	logic signed [15:0] axis_s1;

	ev_ctrl_t           ctrl;

	logic               out_valid_q;
	logic signed [15:0] thr_q;
	logic signed [15:0] str_q;
	logic [7:0]         gear_q;
	logic               arm_q;
	logic               dis_q;
	logic               changed_q;

	logic               out_ready;
	logic               load_s1;
	logic               fire;
	logic               invert;
	logic signed [15:0] mapped;
	logic [7:0]         thr_id;
	logic [7:0]         str_id;
	logic [7:0]         up_id;
	logic [7:0]         dn_id;
	logic [7:0]         arm_id;
	logic [7:0]         dis_id;
	logic               hit_thr;
	logic               hit_str;

	jerm_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	assign out_ready = !out_valid_q || !out_stall;
	assign load_s1   = !valid_s1 || out_ready;
	assign fire      = valid_s1 && out_ready;
	assign in_stall  = !load_s1;

	// event decode
	always_comb begin
		thr_id  = cfg.axis_map[7:0];
		str_id  = cfg.axis_map[15:8];
		up_id   = cfg.button_map[7:0];
		dn_id   = cfg.button_map[15:8];
		arm_id  = cfg.button_map[23:16];
		dis_id  = cfg.button_map[31:24];
		hit_thr = (id_s1 == thr_id);
		hit_str = !hit_thr && (id_s1 == str_id);
		invert  = hit_thr ? cfg.axis_map[16] : cfg.axis_map[17];
		ctrl    = '0;
		case (func_s1)
			FUNC_AXIS: begin
				ctrl.upd_thr = hit_thr;
				ctrl.upd_str = hit_str;
				ctrl.changed = hit_thr || hit_str;
			end
			FUNC_DOWN: begin
				if (id_s1 == up_id) begin
					ctrl.gear_set = 1'b1;
					ctrl.gear_val = 8'd1 << cfg.gear_pos[2:0];
				end else if (id_s1 == dn_id) begin
					ctrl.gear_set = 1'b1;
					ctrl.gear_val = 8'd1 << cfg.gear_pos[5:3];
				end else if (id_s1 == arm_id) begin
					ctrl.arm_set = 1'b1;
				end else if (id_s1 == dis_id) begin
					ctrl.dis_set = 1'b1;
				end
				ctrl.changed = ctrl.gear_set || ctrl.arm_set || ctrl.dis_set;
			end
			FUNC_UP: begin
				ctrl.gear_clr = (id_s1 == up_id) || (id_s1 == dn_id);
				ctrl.arm_clr  = (id_s1 == arm_id);
				ctrl.dis_clr  = (id_s1 == dis_id);
			end
			default: ctrl = '0;
		endcase
	end

	jerm_axis_map #(
		.AXIS_BITS (AXIS_BITS)
	) u_axis (
		.axis_value (axis_s1),
		.invert     (invert),
		.cfg        (cfg),
		.mapped     (mapped)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= in_valid;
			end
			if (out_ready) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			func_s1 <= func_t'(func);
			id_s1   <= control_id;
			axis_s1 <= axis_value;
		end
		if (fire) begin
			changed_q <= ctrl.changed;
		end
	end

	// control state, which also forms the result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= RC_STATE_RST;
			str_q  <= RC_STATE_RST;
			gear_q <= 8'd0;
			arm_q  <= 1'b0;
			dis_q  <= 1'b0;
		end else if (fire) begin
			if (ctrl.upd_thr) begin
				thr_q <= mapped;
			end
			if (ctrl.upd_str) begin
				str_q <= mapped;
			end
			if (ctrl.gear_set) begin
				gear_q <= ctrl.gear_val;
			end else if (ctrl.gear_clr) begin
				gear_q <= 8'd0;
			end
			if (ctrl.arm_set) begin
				arm_q <= 1'b1;
			end else if (ctrl.arm_clr) begin
				arm_q <= 1'b0;
			end
			if (ctrl.dis_set) begin
				dis_q <= 1'b1;
			end else if (ctrl.dis_clr) begin
				dis_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign throttle_out   = thr_q;
	assign steering_out   = str_q;
	assign gear_buttons   = gear_q;
	assign arm_request    = arm_q;
	assign disarm_request = dis_q;
	assign changed        = changed_q;

endmodule

// ----- test/joystick_event_to_rc_mapper_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_event_to_rc_mapper_tb
// Self-checking bench for the joystick event mapper. A small in-bench model of
// the control state predicts one word per accepted event. Each word leaving
// the block is compared field by field with the oldest prediction. Stimulus
// is a directed set at reset and special settings, then random phases. Each
// phase loads new register settings over the config port. Both handshakes
// idle and stall at random.
// ----------------------------------------------------------------------------
module joystick_event_to_rc_mapper_tb;
	import jerm_pkg::*;

	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASES = 13;

	typedef struct packed {
		logic signed [15:0] throttle;
		logic signed [15:0] steering;
		logic [7:0]         gear;
		logic               arm;
		logic               disarm;
		logic               changed;
	} rc_word_t;

	class rc_state_tracker;
		cfg_t               cfg;
		logic signed [15:0] throttle;
		logic signed [15:0] steering;
		logic [7:0]         gear;
		logic               arm;
		logic               disarm;
		rc_word_t           pending_words[$];
		int unsigned        mismatches;

		function new();
			cfg.axis_map   = AXIS_MAP_RST;
			cfg.button_map = BUTTON_MAP_RST;
			cfg.gear_pos   = GEAR_POS_RST;
			cfg.rc_min     = RC_MIN_RST;
			cfg.rc_max     = RC_MAX_RST;
			cfg.rc_centre  = RC_CENTRE_RST;
			cfg.deadzone   = DEADZONE_RST;
			cfg.discrete   = 1'b0;
			throttle       = RC_STATE_RST;
			steering       = RC_STATE_RST;
			gear           = '0;
			arm            = 1'b0;
			disarm         = 1'b0;
			mismatches     = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] word);
			case (idx)
				REG_AXIS_MAP:   cfg.axis_map   = word[17:0];
				REG_BUTTON_MAP: cfg.button_map = word;
				REG_GEAR_POS:   cfg.gear_pos   = word[5:0];
				REG_RC_MIN:     cfg.rc_min     = word[15:0];
				REG_RC_MAX:     cfg.rc_max     = word[15:0];
				REG_RC_CENTRE:  cfg.rc_centre  = word[15:0];
				REG_DEADZONE:   cfg.deadzone   = word[14:0];
				REG_DISCRETE:   cfg.discrete   = word[0];
				default: ;
			endcase
		endfunction

		function logic signed [15:0] pulse_for_axis(logic signed [15:0] raw, logic inv);
			longint n;
			longint d;
			longint lo;
			longint hi;
			longint half;
			longint v;
			n  = raw;
			d  = cfg.deadzone;
			lo = $signed(cfg.rc_min);
			hi = $signed(cfg.rc_max);
			if (n > -d && n < d)
				return cfg.rc_centre;
			if (inv)
				n = -n;
			if (cfg.discrete) begin
				if (n > d)
					return cfg.rc_max;
				if (n < -d)
					return cfg.rc_min;
				return cfg.rc_centre;
			end
			half = (hi - lo) / 2;
			v = $signed(cfg.rc_centre) + (n * half) / 32768;
			if (v < lo)
				v = lo;
			if (v > hi)
				v = hi;
			return v[15:0];
		endfunction

		function void take_event(logic [1:0] f, logic [7:0] id, logic signed [15:0] raw);
			logic [7:0] up_id;
			logic [7:0] dn_id;
			logic [7:0] arm_id;
			logic [7:0] dis_id;
			rc_word_t   w;
			up_id     = cfg.button_map[7:0];
			dn_id     = cfg.button_map[15:8];
			arm_id    = cfg.button_map[23:16];
			dis_id    = cfg.button_map[31:24];
			w.changed = 1'b0;
			case (f)
				FUNC_AXIS: begin
					if (id == cfg.axis_map[7:0]) begin
						throttle  = pulse_for_axis(raw, cfg.axis_map[16]);
						w.changed = 1'b1;
					end else if (id == cfg.axis_map[15:8]) begin
						steering  = pulse_for_axis(raw, cfg.axis_map[17]);
						w.changed = 1'b1;
					end
				end
				FUNC_DOWN: begin
					if (id == up_id) begin
						gear      = 8'd1 << cfg.gear_pos[2:0];
						w.changed = 1'b1;
					end else if (id == dn_id) begin
						gear      = 8'd1 << cfg.gear_pos[5:3];
						w.changed = 1'b1;
					end else if (id == arm_id) begin
						arm       = 1'b1;
						w.changed = 1'b1;
					end else if (id == dis_id) begin
						disarm    = 1'b1;
						w.changed = 1'b1;
					end
				end
				FUNC_UP: begin
					if (id == up_id || id == dn_id)
						gear = '0;
					if (id == arm_id)
						arm = 1'b0;
					if (id == dis_id)
						disarm = 1'b0;
				end
				default: ;
			endcase
			w.throttle = throttle;
			w.steering = steering;
			w.gear     = gear;
			w.arm      = arm;
			w.disarm   = disarm;
			pending_words.push_back(w);
		endfunction

		task flag_mismatch(string msg);
			mismatches++;
			$display("%0t mismatch: %s", $realtime, msg);
		endtask

		task check_word(rc_word_t got);
			rc_word_t want;
			if (pending_words.size() == 0) begin
				flag_mismatch("word out with none expected");
				return;
			end
			want = pending_words.pop_front();
			if (got.throttle !== want.throttle)
				flag_mismatch($sformatf("throttle_out %0d, expected %0d",
					got.throttle, want.throttle));
			if (got.steering !== want.steering)
				flag_mismatch($sformatf("steering_out %0d, expected %0d",
					got.steering, want.steering));
			if (got.gear !== want.gear)
				flag_mismatch($sformatf("gear_buttons %h, expected %h", got.gear, want.gear));
			if (got.arm !== want.arm)
				flag_mismatch($sformatf("arm_request %b, expected %b", got.arm, want.arm));
			if (got.disarm !== want.disarm)
				flag_mismatch($sformatf("disarm_request %b, expected %b",
					got.disarm, want.disarm));
			if (got.changed !== want.changed)
				flag_mismatch($sformatf("changed %b, expected %b", got.changed, want.changed));
		endtask

		function int pending();
			return pending_words.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         func = '0;
	logic [7:0]         control_id = '0;
	logic signed [15:0] axis_value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [15:0] throttle_out;
	logic signed [15:0] steering_out;
	logic [7:0]         gear_buttons;
	logic               arm_request;
	logic               disarm_request;
	logic               changed;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [4:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	rc_state_tracker tracker = new();
	rc_word_t        seen_word;
	bit              calm = 1'b0;
	int unsigned     cycles = 0;

	joystick_event_to_rc_mapper dut (
		.clk,
		.arst_n,
		.in_valid,
		.in_stall,
		.func,
		.control_id,
		.axis_value,
		.out_valid,
		.out_stall,
		.throttle_out,
		.steering_out,
		.gear_buttons,
		.arm_request,
		.disarm_request,
		.changed,
		.psel,
		.penable,
		.pwrite,
		.paddr,
		.pwdata,
		.prdata,
		.pready
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// accepted events and words, sampled as they stood before the edge
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			tracker.take_event(func, control_id, axis_value);
		if (arst_n && out_valid && !out_stall) begin
			seen_word.throttle = throttle_out;
			seen_word.steering = steering_out;
			seen_word.gear     = gear_buttons;
			seen_word.arm      = arm_request;
			seen_word.disarm   = disarm_request;
			seen_word.changed  = changed;
			tracker.check_word(seen_word);
		end
	end

	initial begin : out_stall_gen
		int unsigned hold;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			hold = calm ? 0 : $urandom_range(0, 15);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	task automatic send_event(logic [1:0] f, logic [7:0] id, logic signed [15:0] v);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		func       <= f;
		control_id <= id;
		axis_value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain_words();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (tracker.pending() != 0);
	endtask

	task automatic apb_write(reg_idx_t idx, logic [31:0] word);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		tracker.set_reg(idx, word);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_random_setting();
		logic [31:0]        vals [8];
		logic [31:0]        keep;
		logic signed [15:0] lo;
		logic signed [15:0] hi;
		logic signed [15:0] mid;
		vals[REG_AXIS_MAP] = {14'd0, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 5)),
			8'($urandom_range(0, 5))};
		if ($urandom_range(0, 5) == 0)
			vals[REG_AXIS_MAP][15:0] = 16'($urandom);
		vals[REG_BUTTON_MAP] = {8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)),
			8'($urandom_range(0, 7)), 8'($urandom_range(0, 7))};
		if ($urandom_range(0, 5) == 0)
			vals[REG_BUTTON_MAP] = $urandom;
		vals[REG_GEAR_POS] = $urandom_range(0, 63);
		case ($urandom_range(0, 4))
			0: begin
				lo  = 16'sd1000;
				hi  = 16'sd2000;
				mid = 16'sd1500;
			end
			1: begin
				lo = 16'sh8000;
				hi = 16'sh7fff;
				case ($urandom_range(0, 2))
					0: mid = 16'sh8000;
					1: mid = 16'sd0;
					default: mid = 16'sh7fff;
				endcase
			end
			2: begin
				lo  = 16'($urandom);
				hi  = 16'($urandom);
				mid = 16'($urandom);
			end
			3: begin
				lo  = 16'sd300;
				hi  = -16'sd300;
				mid = 16'($urandom);
			end
			default: begin
				lo  = 16'($urandom_range(0, 3000));
				lo  = -lo;
				hi  = 16'($urandom_range(0, 3000));
				mid = 16'($urandom_range(0, 600));
				mid = mid - 16'sd300;
			end
		endcase
		vals[REG_RC_MIN]    = {16'h0, lo};
		vals[REG_RC_MAX]    = {16'h0, hi};
		vals[REG_RC_CENTRE] = {16'h0, mid};
		case ($urandom_range(0, 4))
			0: vals[REG_DEADZONE] = 0;
			1: vals[REG_DEADZONE] = 32767;
			2: vals[REG_DEADZONE] = DEADZONE_RST;
			3: vals[REG_DEADZONE] = $urandom_range(0, 2000);
			default: vals[REG_DEADZONE] = $urandom_range(0, 32767);
		endcase
		vals[REG_DISCRETE] = $urandom_range(0, 1);
		// spare bits above each register narrower than a word are filled with noise
		for (int i = 0; i < 8; i++) begin
			case (reg_idx_t'(i))
				REG_AXIS_MAP:   keep = 32'h0003_ffff;
				REG_BUTTON_MAP: keep = 32'hffff_ffff;
				REG_GEAR_POS:   keep = 32'h0000_003f;
				REG_DEADZONE:   keep = 32'h0000_7fff;
				REG_DISCRETE:   keep = 32'h0000_0001;
				default:        keep = 32'h0000_ffff;
			endcase
			apb_write(reg_idx_t'(i), (vals[i] & keep) | ($urandom & ~keep));
		end
	endtask

	task automatic random_event();
		logic [1:0]         f;
		logic [7:0]         id;
		logic signed [15:0] v;
		logic signed [15:0] dz;
		int unsigned        pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			f = FUNC_AXIS;
		else if (pick < 70)
			f = FUNC_DOWN;
		else if (pick < 94)
			f = FUNC_UP;
		else
			f = FUNC_NONE;
		pick = $urandom_range(0, 7);
		if (f == FUNC_AXIS && pick < 3)
			id = tracker.cfg.axis_map[7:0];
		else if (f == FUNC_AXIS && pick < 6)
			id = tracker.cfg.axis_map[15:8];
		else if (pick < 6)
			id = tracker.cfg.button_map[8 * $urandom_range(0, 3) +: 8];
		else
			id = 8'($urandom);
		dz = {1'b0, tracker.cfg.deadzone};
		case ($urandom_range(0, 11))
			0: v = 16'sh8000;
			1: v = 16'sh7fff;
			2: v = dz;
			3: v = -dz;
			4: v = dz + 16'sd1;
			5: v = dz - 16'sd1;
			6: v = 16'sd0;
			default: v = 16'($urandom);
		endcase
		send_event(f, id, v);
	endtask

	initial begin : stimulus
		int unsigned count;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// settings at reset: throttle axis 1, steering axis 0, buttons 0 to 3
		send_event(FUNC_AXIS, 8'd0, 16'sh7fff);
		send_event(FUNC_AXIS, 8'd0, 16'sh8000);
		send_event(FUNC_AXIS, 8'd0, 16'sd3277);
		send_event(FUNC_AXIS, 8'd0, 16'sd3276);
		send_event(FUNC_AXIS, 8'd0, -16'sd3277);
		send_event(FUNC_AXIS, 8'd1, 16'sh7fff);
		send_event(FUNC_AXIS, 8'd1, 16'sh8000);
		send_event(FUNC_AXIS, 8'd1, 16'sd0);
		send_event(FUNC_AXIS, 8'd9, 16'sd12345);
		send_event(FUNC_DOWN, 8'd0, 16'sd0);
		send_event(FUNC_DOWN, 8'd1, -16'sd1);
		send_event(FUNC_UP, 8'd0, 16'sd0);
		send_event(FUNC_DOWN, 8'd2, 16'sd0);
		send_event(FUNC_DOWN, 8'd3, 16'sd0);
		send_event(FUNC_UP, 8'd2, 16'sd0);
		send_event(FUNC_UP, 8'd3, 16'sd0);
		send_event(FUNC_DOWN, 8'hff, 16'sd0);
		send_event(FUNC_NONE, 8'd0, 16'sh7fff);
		drain_words();

		// shared axis id, one id for every button role, min above max, no deadzone
		apb_write(REG_AXIS_MAP, 32'h0001_0404);
		apb_write(REG_BUTTON_MAP, 32'h0505_0505);
		apb_write(REG_GEAR_POS, 32'h0000_002a);
		apb_write(REG_RC_MIN, 32'd300);
		apb_write(REG_RC_MAX, {16'h0, -16'sd300});
		apb_write(REG_RC_CENTRE, 32'd0);
		apb_write(REG_DEADZONE, 32'd0);
		send_event(FUNC_AXIS, 8'd4, 16'sh7fff);
		send_event(FUNC_AXIS, 8'd4, 16'sh8000);
		send_event(FUNC_DOWN, 8'd5, 16'sd0);
		send_event(FUNC_UP, 8'd5, 16'sd0);
		send_event(FUNC_AXIS, 8'd4, 16'sd0);
		drain_words();

		for (int phase = 0; phase < PHASES; phase++) begin
			load_random_setting();
			calm  = ($urandom_range(0, 3) == 0);
			count = 50 + $urandom_range(0, 26);
			for (int k = 0; k < count; k++) begin
				random_event();
				if (phase % 3 == 0 && k == count / 2)
					drain_words();
			end
			drain_words();
		end

		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
